// File: hdl/assert_macros.svh
// Assertion helpers for the distance table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PDT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`endif

// File: hdl/pdt_pkg.sv
`default_nettype none

package pdt_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int DIST_W     = 26;
	localparam int DIST_DEPTH = MAX_POINTS * (MAX_POINTS - 1) / 2;
	localparam int SLOT_W     = $clog2(DIST_DEPTH);
	localparam int SUM_W      = 2 * COORD_BITS + 1;
	// root bits: ceil(SUM_W/2) integer bits plus fraction bits
	localparam int PAIRS      = (SUM_W + 1) / 2 + FRAC_BITS;
	localparam int ROOT_W     = PAIRS;
	localparam int REM_W      = ROOT_W + 2;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_UNLOADED = 2'd3
	} status_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                   cmd;
		logic signed [15:0]     coord_x;
		logic signed [15:0]     coord_y;
		logic [IDX_W-1:0]       first_index;
		logic [IDX_W-1:0]       second_index;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		status_t           status;
	} out_item_t;

	// Write request into the distance store.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [DIST_W-1:0] data;
	} dist_wr_t;

endpackage

`default_nettype wire

// File: hdl/pdt_sqrt.sv
`default_nettype none

// Pipelined digit-by-digit square root, one result bit per stage.
module pdt_sqrt (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic [pdt_pkg::SUM_W-1:0]         sum,
	input  wire logic [pdt_pkg::SLOT_W-1:0]        in_slot,
	output pdt_pkg::dist_wr_t                      wr
);
	localparam int P = pdt_pkg::PAIRS;
	localparam int RW = pdt_pkg::REM_W;
	localparam int XW = 2 * P;

	logic          vld_s [P+1];
	logic [XW-1:0] rad_s [P+1];
	logic [RW-1:0] rem_s [P+1];
	logic [P-1:0]  root_s[P+1];
	logic [pdt_pkg::SLOT_W-1:0] slot_s[P+1];

	// radicand scaled by 4^FRAC_BITS, zero-extended into 2*P bits
	always_comb begin
		vld_s[0]  = in_valid;
		rad_s[0]  = XW'(sum) << (2 * pdt_pkg::FRAC_BITS);
		rem_s[0]  = '0;
		root_s[0] = '0;
		slot_s[0] = in_slot;
	end

	for (genvar k = 0; k < P; k++) begin : g_stage
		logic [RW-1:0] rem_n, trial;
		always_comb begin
			rem_n = {rem_s[k][RW-3:0], rad_s[k][XW-1:XW-2]};
			trial = {root_s[k][RW-3:0], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			rad_s[k+1]  <= rad_s[k] << 2;
			slot_s[k+1] <= slot_s[k];
			if (rem_n >= trial) begin
				rem_s[k+1]  <= rem_n - trial;
				root_s[k+1] <= {root_s[k][P-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= rem_n;
				root_s[k+1] <= {root_s[k][P-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		wr.en   = vld_s[P];
		wr.slot = slot_s[P];
		if (P > pdt_pkg::DIST_W && |(root_s[P] >> pdt_pkg::DIST_W)) begin
			wr.data = pdt_pkg::DIST_MAX;
		end else begin
			wr.data = pdt_pkg::DIST_W'(root_s[P]);
		end
	end

endmodule

`default_nettype wire

// File: hdl/pdt_dist_mem.sv
`default_nettype none

// Triangular distance store: one write port, one registered read port.
module pdt_dist_mem (
	input  wire logic                        clk,
	input  wire pdt_pkg::dist_wr_t           wr,
	input  wire logic [pdt_pkg::SLOT_W-1:0]  rd_slot,
	output logic [pdt_pkg::DIST_W-1:0]       rd_data
);
	logic [pdt_pkg::DIST_W-1:0] mem [pdt_pkg::DIST_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.slot] <= wr.data;
		end
		rd_data <= mem[rd_slot];
	end

endmodule

`default_nettype wire

// File: hdl/pairwise_distance_table_core.sv
`default_nettype none
`include "assert_macros.svh"

// Pairwise distance table.
// Command channel: an item (packed struct in) transfers when start is high
// and busy is low. cmd LOAD stores the point at the next index and fills
// the distances to all earlier points; cmd QUERY reads one stored distance.
// Every item yields one result on out, marked by done for one cycle; the
// receiver cannot stall, so results are simply presented.
// Config channel: cfg_valid/cfg_ready writes point_count (clamped to
// 2..MAX_POINTS) and restarts loading at index 0. Ready only when idle and
// start is low, so a command transfer always wins over a config write.
// A query passes through decode, memory read and result.
// A load of point i walks j = 0..i-1 through the coordinate memories, one
// pair per cycle, into the square root pipeline (PAIRS stages, 25 here);
// done follows once the last distance is written. The point memories and
// the root pipeline are fully pipelined: one pair enters per cycle.
// Reset: loaded_count clears and point_count returns to MAX_POINTS; the
// memories are not cleared, since only written entries are ever read.
module pairwise_distance_table_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire pdt_pkg::in_item_t          in,
	output logic                            done,
	output pdt_pkg::out_item_t              out,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [pdt_pkg::CNT_W-1:0]  cfg_data
);
	localparam int CW = pdt_pkg::CNT_W;
	localparam int IW = pdt_pkg::IDX_W;
	localparam int SW = pdt_pkg::SLOT_W;
	localparam int PC = pdt_pkg::COORD_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_QRD, S_QOUT, S_LOAD, S_DRAIN
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       point_count_q, loaded_q;
	logic [IW-1:0]       new_idx_q, j_q;
	logic [SW-1:0]       slot_q;
	logic [CW-1:0]       drain_q;
	pdt_pkg::status_t    status_q;
	logic                eq_q;

	// point memories
	logic signed [PC-1:0] xmem [pdt_pkg::MAX_POINTS];
	logic signed [PC-1:0] ymem [pdt_pkg::MAX_POINTS];
	logic signed [PC-1:0] xrd, yrd, xnew_q, ynew_q;
	logic                 pair_s1;
	logic [SW-1:0]        slot_s1;

	// square / sum stage
	logic [PC:0]            dx, dy;
	logic [pdt_pkg::SUM_W-1:0] sum_s2;
	logic                   pair_s2;
	logic [SW-1:0]          slot_s2;

	pdt_pkg::dist_wr_t      wr;
	logic [SW-1:0]          rd_slot;
	logic [pdt_pkg::DIST_W-1:0] rd_data;

	logic                   acc;
	logic [IW-1:0]          lo_i, hi_i;
	logic                   q_range, q_unl;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign acc       = start && !busy;

	// Packed slot for pair (lo, hi): lo*(n-1) + hi - (lo*(lo+1)/2 + 1).
	function automatic logic [SW-1:0] slot_of(input logic [IW-1:0] lo,
			input logic [IW-1:0] hi, input logic [CW-1:0] n);
		logic [SW+CW:0] t;
		t = (SW+CW+1)'(lo) * (SW+CW+1)'(n - 1'b1) + (SW+CW+1)'(hi)
			- (((SW+CW+1)'(lo) * (SW+CW+1)'(lo + 1'b1)) >> 1) - 1'b1;
		return SW'(t);
	endfunction

	always_comb begin
		lo_i    = (in.first_index < in.second_index) ? in.first_index : in.second_index;
		hi_i    = (in.first_index < in.second_index) ? in.second_index : in.first_index;
		q_range = (CW'(in.first_index) >= point_count_q)
			|| (CW'(in.second_index) >= point_count_q);
		q_unl   = (CW'(in.first_index) >= loaded_q) || (CW'(in.second_index) >= loaded_q);
		rd_slot = slot_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= CW'(pdt_pkg::MAX_POINTS);
			loaded_q      <= '0;
			done          <= 1'b0;
			pair_s1       <= 1'b0;
		end else begin
			done    <= 1'b0;
			pair_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_data < CW'(2)) begin
							point_count_q <= CW'(2);
						end else if (cfg_data > CW'(pdt_pkg::MAX_POINTS)) begin
							point_count_q <= CW'(pdt_pkg::MAX_POINTS);
						end else begin
							point_count_q <= cfg_data;
						end
						loaded_q <= '0;
					end else if (acc) begin
						if (in.cmd == pdt_pkg::CMD_QUERY) begin
							state_q <= S_QRD;
						end else if (loaded_q >= point_count_q) begin
							state_q <= S_QOUT;
						end else begin
							state_q <= (loaded_q == '0) ? S_DRAIN : S_LOAD;
						end
					end
				end
				S_QRD: state_q <= S_QOUT;
				S_QOUT: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_LOAD: begin
					pair_s1 <= 1'b1;
					if (j_q + 1'b1 == new_idx_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drain_q == '0) begin
						done     <= 1'b1;
						loaded_q <= loaded_q + 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc) begin
			new_idx_q <= IW'(loaded_q);
			j_q       <= '0;
			xnew_q    <= in.coord_x;
			ynew_q    <= in.coord_y;
			drain_q   <= CW'(pdt_pkg::PAIRS + 3);
			slot_q    <= slot_of(lo_i, hi_i, point_count_q);
			out.distance <= '0;
			if (in.cmd == pdt_pkg::CMD_QUERY) begin
				status_q <= q_range ? pdt_pkg::ST_RANGE
					: q_unl ? pdt_pkg::ST_UNLOADED : pdt_pkg::ST_OK;
			end else begin
				status_q <= (loaded_q >= point_count_q) ? pdt_pkg::ST_FULL : pdt_pkg::ST_OK;
				if (loaded_q < point_count_q) begin
					xmem[IW'(loaded_q)] <= in.coord_x;
					ymem[IW'(loaded_q)] <= in.coord_y;
				end
			end
			// equal indices use no stored distance: eq_q forces a zero distance
			out.status <= pdt_pkg::ST_OK;
		end
		if (state_q == S_LOAD) begin
			j_q     <= j_q + 1'b1;
			slot_s1 <= slot_of(j_q, new_idx_q, point_count_q);
		end
		if (state_q == S_DRAIN) begin
			drain_q <= drain_q - 1'b1;
		end
		xrd <= xmem[j_q];
		yrd <= ymem[j_q];
		if (state_q == S_QRD) begin
			out.status <= status_q;
		end
		if (state_q == S_QOUT) begin
			out.status <= status_q;
			if (status_q == pdt_pkg::ST_OK && !eq_q) begin
				out.distance <= rd_data;
			end else begin
				out.distance <= '0;
			end
		end
		if (state_q == S_DRAIN && drain_q == '0) begin
			out.status   <= pdt_pkg::ST_OK;
			out.distance <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc) begin
			eq_q <= (in.cmd == pdt_pkg::CMD_LOAD) || (in.first_index == in.second_index);
		end
	end

	// stage 2: squared differences
	always_comb begin
		dx = (xrd >= xnew_q) ? (PC+1)'($signed({xrd[PC-1], xrd}) - $signed({xnew_q[PC-1], xnew_q}))
			: (PC+1)'($signed({xnew_q[PC-1], xnew_q}) - $signed({xrd[PC-1], xrd}));
		dy = (yrd >= ynew_q) ? (PC+1)'($signed({yrd[PC-1], yrd}) - $signed({ynew_q[PC-1], ynew_q}))
			: (PC+1)'($signed({ynew_q[PC-1], ynew_q}) - $signed({yrd[PC-1], yrd}));
	end

	logic [2*PC+1:0] sqx_s2, sqy_s2;
	logic            pair_s3;
	logic [SW-1:0]   slot_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_s2 <= 1'b0;
			pair_s3 <= 1'b0;
		end else begin
			pair_s2 <= pair_s1;
			pair_s3 <= pair_s2;
		end
	end
	always_ff @(posedge clk) begin
		sqx_s2  <= dx * dx;
		sqy_s2  <= dy * dy;
		slot_s2 <= slot_s1;
		sum_s2  <= pdt_pkg::SUM_W'(sqx_s2 + sqy_s2);
		slot_s3 <= slot_s2;
	end

	pdt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pair_s3),
		.sum      (sum_s2),
		.in_slot  (slot_s3),
		.wr       (wr)
	);

	pdt_dist_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_slot (rd_slot),
		.rd_data (rd_data)
	);

	`PDT_ASSERT(a_no_write_idle, !(wr.en && state_q == S_IDLE), "write while idle")
	`PDT_ASSERT(a_count_le, loaded_q <= point_count_q, "loaded exceeds count")
	`PDT_ASSERT(a_done_idle, done |-> state_q == S_IDLE, "done outside idle")

endmodule

`default_nettype wire
